[rtl/core/firdf_pkg.sv]
// ----------------------------------------------------------------------------
// FIR direct-form filter package
// Shared widths, command codes, payload structs and controller types.
// ----------------------------------------------------------------------------
package firdf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int NUM_COEF    = 8;
	localparam int COEF_IDX_W  = $clog2(NUM_COEF);
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = COEF_W;
	localparam int FRAC_BITS   = 15;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_PEEK = 2'd1,
		CMD_FILL = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       saturated;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic last;
	} mac_ctrl_t;

endpackage

[rtl/core/firdf_mac.sv]
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// One registered product per cycle, an exact accumulator, then rounding and
// saturation of the finished sum to a 16-bit sample.
// ----------------------------------------------------------------------------
module firdf_mac #(
	parameter int TAPS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  firdf_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [firdf_pkg::SAMPLE_W-1:0] tap_sample,
	input  logic signed [firdf_pkg::COEF_W-1:0]   coef,
	output logic                                 done,
	output firdf_pkg::res_t                      res
);

	localparam int ACC_W = firdf_pkg::PROD_W + $clog2(TAPS);
	localparam int Q_W   = ACC_W + 1 - firdf_pkg::FRAC_BITS;
	localparam logic signed [ACC_W:0] ROUND_BIAS =
		(ACC_W+1)'(1 << (firdf_pkg::FRAC_BITS - 1));

	logic signed [firdf_pkg::PROD_W-1:0] prod_s2;
	logic                                en_s2;
	logic                                last_s2;
	logic signed [ACC_W-1:0]             acc_q;
	logic                                done_q;

	logic signed [ACC_W:0]   biased;
	logic signed [Q_W-1:0]   q_val;
	logic                    fits;

	always_ff @(posedge clk) begin
		prod_s2 <= tap_sample * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s2   <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			en_s2   <= ctrl.en;
			last_s2 <= ctrl.last;
			done_q  <= en_s2 && last_s2;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (en_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Round half up, then the result fits when every bit above the sample
	// width repeats the sample's sign bit.
	always_comb begin
		biased = (ACC_W+1)'(acc_q) + ROUND_BIAS;
		q_val  = biased[ACC_W:firdf_pkg::FRAC_BITS];
		fits   = (q_val[Q_W-1:firdf_pkg::SAMPLE_W-1] == '0) ||
			(q_val[Q_W-1:firdf_pkg::SAMPLE_W-1] == '1);
		if (fits) begin
			res.filtered  = q_val[firdf_pkg::SAMPLE_W-1:0];
			res.saturated = 1'b0;
		end else if (q_val[Q_W-1]) begin
			res.filtered  = {1'b1, {(firdf_pkg::SAMPLE_W-1){1'b0}}};
			res.saturated = 1'b1;
		end else begin
			res.filtered  = {1'b0, {(firdf_pkg::SAMPLE_W-1){1'b1}}};
			res.saturated = 1'b1;
		end
	end

	assign done = done_q;

endmodule

[rtl/core/fir_direct_form_filter_top.sv]
// ----------------------------------------------------------------------------
// FIR direct-form filter
// Delay line in a small synchronous RAM used as a circular buffer.
// ----------------------------------------------------------------------------
// The item channel (item_valid / item_ready / item) carries a command and a
// sample: push shifts the sample in as the newest tap, peek leaves the line
// alone, fill sets every tap to the sample. Each item yields one transfer on
// the result channel (res_valid / res_ready / res) with the rounded,
// saturated dot product of the line and the coefficients.
// Coefficients are written through cfg_we / cfg_idx / cfg_data; the user
// writes them only while idle, which the block itself does not enforce.
// Indexes beyond the eight registers are ignored. One item is processed at
// a time. The result becomes valid in the same cycle in which a new item
// can be taken. Taps pass through the single RAM read port and the single
// multiplier, one tap per cycle.
// A finished result waits in the output register while the receiver stalls;
// the block holds its sum until the register frees up.
// Reset clears the coefficients, the result valid flag and the per-tap valid
// bits; a tap that is not valid reads as the last fill value, zero after
// reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fir_direct_form_filter_top #(
	parameter int TAPS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  firdf_pkg::item_t                       item,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output firdf_pkg::res_t                        res,
	input  logic                                   cfg_we,
	input  logic [firdf_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [firdf_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
	localparam logic [IDX_W:0]   TAPS_CNT = (IDX_W+1)'(TAPS);

	logic signed [firdf_pkg::COEF_W-1:0]   coef_q [firdf_pkg::NUM_COEF];
	logic signed [firdf_pkg::SAMPLE_W-1:0] mem [TAPS];
	logic [TAPS-1:0]                       tap_vld_q;
	logic signed [firdf_pkg::SAMPLE_W-1:0] fill_q;
	logic [IDX_W-1:0]                      head_q;
	logic [IDX_W-1:0]                      k_q;
	firdf_pkg::state_t                     state_q, state_d;

	logic signed [firdf_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic                                  vld_s1;
	logic [IDX_W-1:0]                      k_s1;
	logic                                  en_s1;
	logic                                  last_s1;

	logic                                  res_valid_q;
	firdf_pkg::res_t                       res_q;

	logic                                  accept;
	logic                                  do_push;
	logic                                  do_fill;
	logic                                  issue;
	logic                                  load;
	logic [IDX_W-1:0]                      head_dec;
	logic [IDX_W:0]                        addr_sum;
	logic [IDX_W-1:0]                      rd_addr;
	logic signed [firdf_pkg::SAMPLE_W-1:0] tap_sample;
	firdf_pkg::mac_ctrl_t                  mac_ctrl;
	logic                                  mac_done;
	firdf_pkg::res_t                       mac_res;

	assign accept  = item_valid && item_ready;
	assign do_push = accept && (item.cmd == firdf_pkg::CMD_PUSH);
	assign do_fill = accept && (item.cmd == firdf_pkg::CMD_FILL);

	// The newest sample goes one slot below the head, so tap k sits at
	// head + k modulo TAPS.
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign addr_sum = {1'b0, head_q} + {1'b0, k_q};
	assign rd_addr  = (addr_sum >= TAPS_CNT) ? IDX_W'(addr_sum - TAPS_CNT)
		: addr_sum[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < firdf_pkg::NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we &&
			(cfg_idx < firdf_pkg::CFG_IDX_W'(firdf_pkg::NUM_COEF))) begin
			coef_q[cfg_idx[firdf_pkg::COEF_IDX_W-1:0]] <= cfg_data;
		end
	end

	// Delay line RAM: write on a push transfer, read one tap per issue cycle.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[head_dec] <= item.sample;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_q <= '0;
			head_q    <= '0;
			fill_q    <= '0;
		end else if (do_push) begin
			tap_vld_q[head_dec] <= 1'b1;
			head_q              <= head_dec;
		end else if (do_fill) begin
			tap_vld_q <= '0;
			fill_q    <= item.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= firdf_pkg::ST_IDLE;
			k_q     <= '0;
			en_s1   <= 1'b0;
			last_s1 <= 1'b0;
			vld_s1  <= 1'b0;
			k_s1    <= '0;
		end else begin
			state_q <= state_d;
			en_s1   <= issue;
			last_s1 <= issue && (k_q == LAST_IDX);
			vld_s1  <= tap_vld_q[rd_addr];
			k_s1    <= k_q;
			if (accept) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			firdf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = firdf_pkg::ST_ISSUE;
				end
			end
			firdf_pkg::ST_ISSUE: begin
				if (k_q == LAST_IDX) begin
					state_d = firdf_pkg::ST_DRAIN;
				end
			end
			firdf_pkg::ST_DRAIN: begin
				if (mac_done) begin
					state_d = firdf_pkg::ST_DONE;
				end
			end
			firdf_pkg::ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					state_d = firdf_pkg::ST_IDLE;
				end
			end
			default: state_d = firdf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		issue      = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			firdf_pkg::ST_IDLE:  item_ready = 1'b1;
			firdf_pkg::ST_ISSUE: issue      = 1'b1;
			firdf_pkg::ST_DRAIN: ;
			firdf_pkg::ST_DONE:  load       = !res_valid_q || res_ready;
			default: ;
		endcase
	end

	assign tap_sample     = vld_s1 ? rd_data_s1 : fill_q;
	assign mac_ctrl.clear = accept;
	assign mac_ctrl.en    = en_s1;
	assign mac_ctrl.last  = last_s1;

	firdf_mac #(
		.TAPS(TAPS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.tap_sample(tap_sample),
		.coef      (coef_q[firdf_pkg::COEF_IDX_W'(k_s1)]),
		.done      (mac_done),
		.res       (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= mac_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/firdf_checker.sv]
// ----------------------------------------------------------------------------
// FIR direct-form filter port checker
// Watches the top level's channels and flags handshake or result slips.
// ----------------------------------------------------------------------------
module firdf_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_ready,
	input logic            res_valid,
	input logic            res_ready,
	input firdf_pkg::res_t res
);

	// A stalled result must hold its value until its transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// Items are processed one at a time.
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while one is in flight");

	// No result can appear right after an item transfer.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(res_valid))
		else $error("result appeared too soon after an item transfer");

	// A clipped result sits at one of the two range limits.
	a_sat_limits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.saturated |->
		(res.filtered == 16'sh7fff) || (res.filtered == 16'sh8000))
		else $error("saturated flag set on an unclipped value");

endmodule

bind fir_direct_form_filter_top firdf_checker u_firdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
